// ----- design/sktd_pkg.sv -----
`default_nettype none
package sktd_pkg;

    localparam int TableDepthDefault = 256;
    localparam int KeyMaxBytesDefault = 8;
    localparam int ItemCap = 65536;

    localparam logic [0:0] CMD_INSERT = 1'b0;
    localparam logic [0:0] CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [0:0] REG_KEY_BYTES  = 1'b0;
    localparam logic [0:0] REG_ITEM_LIMIT = 1'b1;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [63:0] key;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [16:0] multiplicity;
        logic [15:0] first_item;
        logic [8:0]  distinct_count;
        logic [1:0]  status;
    } out_word_t;

    // one table entry as held in memory
    typedef struct packed {
        logic [63:0] key;
        logic [16:0] count;
        logic [15:0] first_item;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic       wr_en;
        logic [15:0] wr_addr;
        logic [15:0] rd_addr;
        logic       rd_en;
    } mem_ctl_t;

endpackage
`default_nettype wire

// ----- design/sktd_mem.sv -----
`default_nettype none
module sktd_mem
    import sktd_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic   clk,
    input  wire mem_ctl_t ctl,
    input  wire entry_t wr_data,
    output entry_t      rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

// ----- design/sorted_key_table_dedup_count_unit.sv -----
// Sorted key table with counts. Each word is processed alone. The n held entries are
// scanned through the table memory, one read per cycle, to find the slot. The entry
// at the slot is then read back and tested for a match. A counted known key adds a
// write of its entry. A new key first moves each entry above the slot up with a read
// and a write on separate cycles, then writes its own entry at the slot. The next
// input word is taken the cycle after the result word leaves. The result word is
// held in an output register.
`default_nettype none
module sorted_key_table_dedup_count_unit
    import sktd_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault,
    parameter int KEY_MAX_BYTES = KeyMaxBytesDefault
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [3:0]  key_bytes_reg;
    logic [16:0] item_limit_reg;
    logic [CW-1:0] total_reg, total_next;
    logic [16:0] taken_reg, taken_next;
    logic [0:0]  cmd_reg, cmd_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] mask_reg, mask_next;
    logic [CW-1:0] idx_reg, idx_next;   // scan/shift position
    logic [CW-1:0] slot_reg, slot_next;
    logic        rd_pend_reg, rd_pend_next;
    out_word_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    entry_t      ins_reg, ins_next;

    mem_ctl_t ctl;
    entry_t   wr_data, rd_data;

    sktd_mem #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .clk(clk), .ctl(ctl), .wr_data(wr_data), .rd_data(rd_data)
    );

    function automatic logic [63:0] mask_of(input logic [3:0] kb);
        logic [3:0] k;
        logic [63:0] m;
        k = (kb > 4'(KEY_MAX_BYTES)) ? 4'(KEY_MAX_BYTES) : kb;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < k)
            begin
                m[63 - 8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_bytes_reg  <= 4'd8;
            item_limit_reg <= 17'(ItemCap);
            total_reg      <= '0;
            taken_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_BYTES:  key_bytes_reg  <= cfg_data[3:0];
                    REG_ITEM_LIMIT: item_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        mask_reg <= mask_next;
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        out_reg  <= out_next;
        ins_reg  <= ins_next;
    end

    logic [16:0] limit;
    logic        hit;
    logic        found;
    assign limit = (item_limit_reg > 17'(ItemCap)) ? 17'(ItemCap) : item_limit_reg;
    assign hit = ((rd_data.key & mask_reg) == key_reg);

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        taken_next     = taken_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        ins_next       = ins_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_pend_next   = 1'b0;
        ctl            = '0;
        wr_data        = ins_reg;
        found          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd_next  = in_data.cmd;
                    mask_next = mask_of(key_bytes_reg);
                    key_next  = in_data.key & mask_of(key_bytes_reg);
                    ins_next.key = in_data.key;
                    idx_next  = '0;
                    slot_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // count entries below the key, one read per cycle
                if (rd_pend_reg && ((rd_data.key & mask_reg) < key_reg))
                begin
                    slot_next = slot_reg + 1'b1;
                end
                if (idx_reg < total_reg)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = 16'(idx_reg);
                    rd_pend_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = 16'(slot_reg[AW-1:0]);
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                found = (slot_reg < total_reg) && hit;
                out_next.found          = found;
                out_next.slot           = 8'(slot_reg);
                out_next.multiplicity   = found ? rd_data.count : '0;
                out_next.first_item     = found ? rd_data.first_item : '0;
                out_next.distinct_count = 9'(total_reg);
                out_next.status         = ST_OK;
                state_next = S_OUT;
                if (cmd_reg == CMD_INSERT)
                begin
                    priority if (taken_reg >= limit)
                    begin
                        out_next.status = ST_LIMIT;
                    end
                    else if (found)
                    begin
                        ins_next = rd_data;
                        ins_next.count = rd_data.count + 1'b1;
                        out_next.multiplicity = rd_data.count + 1'b1;
                        taken_next = taken_reg + 1'b1;
                        state_next = S_WRITE;
                    end
                    else if (total_reg >= CW'(TABLE_DEPTH))
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        ins_next.count      = 17'd1;
                        ins_next.first_item = taken_reg[15:0];
                        out_next.multiplicity = 17'd1;
                        out_next.first_item   = taken_reg[15:0];
                        out_next.distinct_count = 9'(total_reg + 1'b1);
                        taken_next = taken_reg + 1'b1;
                        idx_next   = total_reg;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // move entry idx-1 up to idx; read issued, data next cycle
                if (rd_pend_reg)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = 16'(idx_reg);
                    wr_data     = rd_data;
                    idx_next    = idx_reg - 1'b1;
                end
                else if (idx_reg > slot_reg)
                begin
                    ctl.rd_en    = 1'b1;
                    ctl.rd_addr  = 16'(idx_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = 16'(slot_reg[AW-1:0]);
                wr_data     = ins_reg;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire
